[rtl/mciir_pkg.sv]
// ----------------------------------------------------------------------------
// mciir_pkg: shared types and constants
// Function codes, widths and controller states of the multichannel IIR.
// ----------------------------------------------------------------------------
`default_nettype none
package mciir_pkg;
	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned COEF_W   = 32;
	localparam int unsigned ACC_W    = 64;
	localparam int unsigned ROUND_SHIFT = 28;

	typedef enum logic [1:0] {
		FUNC_FILTER = 2'd0,
		FUNC_COEF   = 2'd1,
		FUNC_ARM    = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FETCH,
		ST_MUL,
		ST_ACC,
		ST_CHECK,
		ST_SHIFT,
		ST_OUT
	} state_t;

	// request to the bit-serial multiplier and its reply
	typedef struct packed {
		logic                     start;
		logic signed [COEF_W-1:0]   coef;
		logic signed [SAMPLE_W-1:0] data;
	} mul_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [ACC_W-1:0] prod;
	} mul_rsp_t;
endpackage
`default_nettype wire

[rtl/mciir_stream_if.sv]
// ----------------------------------------------------------------------------
// mciir_stream_if: valid/ready channel
// Generic payload channel with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none
interface mciir_stream_if #(
	parameter int unsigned W = 8
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/mciir_in_if.sv]
// ----------------------------------------------------------------------------
// mciir_in_if: input request channel
// Carries func, channel, sample and coefficient fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface mciir_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [2:0]  channel;
	logic signed [23:0] sample;
	logic [4:0]  coef_index;
	logic signed [31:0] coef_value;
	modport source (output valid, output func, output channel, output sample,
		output coef_index, output coef_value, input ready);
	modport sink (input valid, input func, input channel, input sample,
		input coef_index, input coef_value, output ready);
endinterface
`default_nettype wire

[rtl/mciir_out_if.sv]
// ----------------------------------------------------------------------------
// mciir_out_if: result channel
// Carries the filtered sample and the bypass flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface mciir_out_if;
	logic        valid;
	logic        ready;
	logic signed [23:0] sample_out;
	logic        bypassed;
	modport source (output valid, output sample_out, output bypassed, input ready);
	modport sink (input valid, input sample_out, input bypassed, output ready);
endinterface
`default_nettype wire

[rtl/mciir_mul.sv]
// ----------------------------------------------------------------------------
// mciir_mul: bit-serial signed multiplier
// Shift-add of a 24-bit sample by a 32-bit coefficient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mciir_mul
	import mciir_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_req_t req,
	output mul_rsp_t      rsp
);
	localparam int unsigned CNT_W = $clog2(SAMPLE_W + 1);

	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [SAMPLE_W-1:0]     mplr_q;
	logic signed [ACC_W-1:0] mcnd_q;
	logic signed [ACC_W-1:0] prod_q;
	logic                    last;

	// the sample's top bit weighs negative
	assign last = (cnt_q == CNT_W'(SAMPLE_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mplr_q <= req.data;
			mcnd_q <= ACC_W'(req.coef);
			prod_q <= '0;
		end else if (busy_q) begin
			if (mplr_q[0]) begin
				if (last) prod_q <= prod_q - mcnd_q;
				else      prod_q <= prod_q + mcnd_q;
			end
			mplr_q <= mplr_q >> 1;
			mcnd_q <= mcnd_q <<< 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;
endmodule
`default_nettype wire

[rtl/multichannel_iir_direct_form_one.sv]
// ----------------------------------------------------------------------------
// multichannel_iir_direct_form_one: multichannel direct-form-I IIR filter
// Shared bit-serial MAC over per-channel input and output histories.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_ch   | sink      | func, channel, sample, coef_index, coef_value
//  out_ch  | source    | sample_out, bypassed
//  cfg_ch  | sink      | active_order (4 bits)
//
// A filter request is taken in the idle state, then runs 2*m+1 taps (m =
// active order, clamped to 1..ORDER), each tap a fetch, a multiplier start,
// SAMPLE_W multiplier steps and an accumulate, then a check, a read and a
// write for each of the m-1 history entries moved, and a write-back. A
// coefficient write is stored as it is taken; an arm request or an overflow
// clears the CHANNELS*ORDER history entries, one entry per cycle. After reset
// a clearing pass runs before the first request is taken. A held result
// stalls the input until it is taken.
`default_nettype none
module multichannel_iir_direct_form_one
	import mciir_pkg::*;
#(
	parameter int unsigned ORDER    = 8,
	parameter int unsigned CHANNELS = 8
)(
	input wire logic clk,
	input wire logic arst_n,
	mciir_in_if.sink      in_ch,
	mciir_out_if.source   out_ch,
	mciir_stream_if.sink  cfg_ch
);
	localparam int unsigned NCOEF = 2 * ORDER + 1;
	localparam int unsigned DEPTH = CHANNELS * ORDER;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(NCOEF);
	localparam int unsigned KW    = $clog2(ORDER + 1);
	localparam int unsigned TW    = $clog2(2 * ORDER + 2);

	state_t state_q, state_d;

	logic [3:0]                active_order_q;
	logic                      armed_q;
	logic signed [COEF_W-1:0]  coef_q [NCOEF];
	logic signed [SAMPLE_W-1:0] xh_mem [DEPTH];
	logic signed [SAMPLE_W-1:0] yh_mem [DEPTH];
	logic signed [SAMPLE_W-1:0] xh_rd_q, yh_rd_q;

	logic [AW-1:0]             clr_q;
	logic [TW-1:0]             tap_q;
	logic [KW-1:0]             m_q, k_q;
	logic                      sh_ph_q;
	logic [AW-1:0]             base_q;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                      out_valid_q;
	logic signed [SAMPLE_W-1:0] out_smp_q;
	logic                      out_byp_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	mciir_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	// ---- request decode ----
	logic in_fire, cfg_fire, take;
	logic [KW-1:0] m_eff;
	logic signed [ACC_W-1:0] rsum;
	logic signed [ACC_W-ROUND_SHIFT-1:0] rnd;
	logic ovf;

	assign cfg_ch.ready = 1'b1;
	assign cfg_fire     = cfg_ch.valid;
	assign take         = (state_q == ST_IDLE) && !(out_valid_q && !out_ch.ready);
	assign in_ch.ready  = take;
	assign in_fire      = in_ch.valid && take;

	always_comb begin
		if (active_order_q == 4'd0)                 m_eff = KW'(1);
		else if (32'(active_order_q) > ORDER)      m_eff = KW'(ORDER);
		else                                       m_eff = KW'(active_order_q);
	end

	// round half up, then check the Q1.23 range
	assign rsum = acc_q + (ACC_W'(1) <<< (ROUND_SHIFT - 1));
	assign rnd  = rsum[ACC_W-1:ROUND_SHIFT];
	assign ovf  = (rnd[ACC_W-ROUND_SHIFT-1:SAMPLE_W-1] != '0)
		&& (rnd[ACC_W-ROUND_SHIFT-1:SAMPLE_W-1] != '1);

	// tap operands: tap 0 is b0*x, odd taps feedforward, even taps feedback
	logic [KW-1:0] tk;
	logic [CW-1:0] cidx;
	logic signed [SAMPLE_W-1:0] opnd;
	always_comb begin
		tk = KW'((tap_q - 1'b1) >> 1);
		if (tap_q == '0) begin
			cidx = '0;
			opnd = smp_q;
		end else if (tap_q[0]) begin
			cidx = CW'(32'(tk) + 1);
			opnd = xh_rd_q;
		end else begin
			cidx = CW'(32'(tk) + 1 + ORDER);
			opnd = yh_rd_q;
		end
	end
	assign mreq.start = (state_q == ST_MUL);
	assign mreq.coef  = coef_q[cidx];
	assign mreq.data  = opnd;

	logic last_tap;
	assign last_tap = (tap_q == TW'(2 * 32'(m_q)));

	// ---- controller ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_ch.func == FUNC_ARM) state_d = ST_CLEAR;
				else if (in_fire && in_ch.func == FUNC_FILTER && armed_q
					&& 32'(in_ch.channel) < CHANNELS) state_d = ST_FETCH;
			end
			ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_FETCH: state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   if (mrsp.done) state_d = last_tap ? ST_CHECK : ST_FETCH;
			ST_CHECK: state_d = ovf ? ST_CLEAR : (m_q > KW'(1) ? ST_SHIFT : ST_OUT);
			ST_SHIFT: if (sh_ph_q && k_q == KW'(1)) state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_order_q <= 4'd1;
			armed_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			clr_q          <= '0;
		end else begin
			if (cfg_fire) active_order_q <= cfg_ch.data[3:0];
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == ST_CLEAR) clr_q <= (clr_q == AW'(DEPTH - 1)) ? '0 : clr_q + 1'b1;
			if (in_fire && in_ch.func == FUNC_ARM) armed_q <= 1'b1;
			// dry pass-through while disarmed or on an unknown channel
			if (in_fire && in_ch.func == FUNC_FILTER
				&& !(armed_q && 32'(in_ch.channel) < CHANNELS))
				out_valid_q <= 1'b1;
			if (state_q == ST_CHECK && ovf) begin
				armed_q     <= 1'b0;
				out_valid_q <= 1'b1;
			end
			if (state_q == ST_OUT) out_valid_q <= 1'b1;
		end
	end

	// coefficient table, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
		end else if (in_fire && in_ch.func == FUNC_COEF
			&& 32'(in_ch.coef_index) < NCOEF) begin
			coef_q[in_ch.coef_index[CW-1:0]] <= in_ch.coef_value;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			smp_q  <= in_ch.sample;
			m_q    <= m_eff;
			base_q <= AW'(32'(in_ch.channel) * ORDER);
			tap_q  <= '0;
			acc_q  <= '0;
			if (in_ch.func == FUNC_FILTER) begin
				out_smp_q <= in_ch.sample;
				out_byp_q <= 1'b1;
			end
		end
		if (state_q == ST_FETCH) begin
			xh_rd_q <= xh_mem[base_q + AW'(tk)];
			yh_rd_q <= yh_mem[base_q + AW'(tk)];
		end
		if (state_q == ST_ACC && mrsp.done) begin
			acc_q <= acc_q + mrsp.prod;
			tap_q <= tap_q + 1'b1;
		end
		if (state_q == ST_CHECK) begin
			res_q   <= rnd[SAMPLE_W-1:0];
			k_q     <= m_q - 1'b1;
			sh_ph_q <= 1'b0;
			if (ovf) begin
				out_smp_q <= smp_q;
				out_byp_q <= 1'b1;
			end
		end
		// move the history one place older, oldest first: read, then write
		if (state_q == ST_SHIFT) begin
			if (!sh_ph_q) begin
				xh_rd_q <= xh_mem[base_q + AW'(k_q - 1'b1)];
				yh_rd_q <= yh_mem[base_q + AW'(k_q - 1'b1)];
			end else begin
				xh_mem[base_q + AW'(k_q)] <= xh_rd_q;
				yh_mem[base_q + AW'(k_q)] <= yh_rd_q;
				k_q <= k_q - 1'b1;
			end
			sh_ph_q <= !sh_ph_q;
		end
		if (state_q == ST_OUT) begin
			xh_mem[base_q] <= smp_q;
			yh_mem[base_q] <= res_q;
			out_smp_q      <= res_q;
			out_byp_q      <= 1'b0;
		end
		if (state_q == ST_CLEAR) begin
			xh_mem[clr_q] <= '0;
			yh_mem[clr_q] <= '0;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_smp_q;
	assign out_ch.bypassed   = out_byp_q;

	// ---- checks ----
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("request taken while busy");
	a_ovf_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && ovf) |=> (!armed_q && state_q == ST_CLEAR))
		else $error("overflow did not disarm");
	a_wet_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> armed_q) else $error("wet result while disarmed");
	a_hold_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> $stable(smp_q)) else $error("sample lost mid shift");
endmodule
`default_nettype wire

[tb/mciir_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mciir_checker: result predictor and scoreboard
// Watches the request, result and order channels and keeps its own copy of
// the coefficients, histories, arm flag and order. Each filter request adds
// one expected result, and each result is compared with the oldest one.
// ----------------------------------------------------------------------------
module mciir_checker
	import mciir_pkg::*;
#(
	parameter int ORDER    = 8,
	parameter int CHANNELS = 8
)(
	input logic   clk,
	input logic   arst_n,
	mciir_in_if   in_mon,
	mciir_out_if  out_mon,
	mciir_stream_if cfg_mon,
	output int    errors,
	output int    outstanding
);
	typedef struct packed {
		logic signed [23:0] smp;
		logic               byp;
	} filt_res_t;

	filt_res_t          due_q[$];
	logic signed [31:0] coefs [0:2*ORDER];
	logic signed [23:0] x_hist [0:CHANNELS-1][0:ORDER-1];
	logic signed [23:0] y_hist [0:CHANNELS-1][0:ORDER-1];
	logic               armed;
	logic [3:0]         order_reg;

	task automatic clear_hist();
		for (int c = 0; c < CHANNELS; c++)
			for (int k = 0; k < ORDER; k++) begin
				x_hist[c][k] = '0;
				y_hist[c][k] = '0;
			end
	endtask

	task automatic filter_sample(input logic [2:0] ch, input logic signed [23:0] x);
		int        m;
		longint    acc;
		longint    r;
		filt_res_t res;
		if (!armed || int'(ch) >= CHANNELS) begin
			res = '{x, 1'b1};
		end else begin
			m = (order_reg < 1) ? 1 : (order_reg > ORDER) ? ORDER : int'(order_reg);
			acc = longint'(coefs[0]) * longint'(x);
			for (int k = 0; k < m; k++) begin
				acc += longint'(coefs[1 + k]) * longint'(x_hist[ch][k]);
				acc += longint'(coefs[1 + ORDER + k]) * longint'(y_hist[ch][k]);
			end
			r = (acc + (longint'(1) <<< 27)) >>> 28;
			if (r < -(longint'(1) <<< 23) || r > (longint'(1) <<< 23) - 1) begin
				clear_hist();
				armed = 1'b0;
				res = '{x, 1'b1};
			end else begin
				for (int k = m - 1; k > 0; k--) begin
					x_hist[ch][k] = x_hist[ch][k-1];
					y_hist[ch][k] = y_hist[ch][k-1];
				end
				x_hist[ch][0] = x;
				y_hist[ch][0] = r[23:0];
				res = '{r[23:0], 1'b0};
			end
		end
		due_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		filt_res_t want;
		if (!arst_n) begin
			for (int i = 0; i <= 2*ORDER; i++) coefs[i] = '0;
			clear_hist();
			armed = 1'b0;
			order_reg = 4'd1;
			due_q.delete();
			errors = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				order_reg = cfg_mon.data[3:0];
			if (in_mon.valid && in_mon.ready) begin
				case (func_t'(in_mon.func))
					FUNC_FILTER: filter_sample(in_mon.channel, in_mon.sample);
					FUNC_COEF: if (in_mon.coef_index <= 2*ORDER)
						coefs[in_mon.coef_index] = in_mon.coef_value;
					FUNC_ARM: begin
						clear_hist();
						armed = 1'b1;
					end
					default: ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				if (due_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: sample_out=%0d bypassed=%0b",
							out_mon.sample_out, out_mon.bypassed);
					errors++;
				end else begin
					want = due_q.pop_front();
					if (want.smp !== out_mon.sample_out || want.byp !== out_mon.bypassed) begin
						if (errors < 10)
							$display("mismatch: expected %0d/%0b, got %0d/%0b",
								want.smp, want.byp, out_mon.sample_out, out_mon.bypassed);
						errors++;
					end
				end
			end
		end
		outstanding = due_q.size();
	end
endmodule

[tb/tb_multichannel_iir_direct_form_one.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_iir_direct_form_one: stimulus and verdict
// Drives directed and random coefficient, arm, filter and no-op requests through
// phases of different filter orders and idling patterns; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_multichannel_iir_direct_form_one;
	import mciir_pkg::*;

	localparam int SETTLE    = 700;    // worst filter pass plus margin
	localparam int WDOG_MAX  = 20000;  // cycles with no handshake at all
	localparam int LONG_HOLD = 3000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   gap_pct;
	int   stall_pct;
	bit   long_hold;

	mciir_in_if             in_bus();
	mciir_out_if            out_bus();
	mciir_stream_if #(.W(4)) cfg_bus();

	multichannel_iir_direct_form_one dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus),
		.cfg_ch (cfg_bus)
	);

	mciir_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_bus),
		.out_mon     (out_bus),
		.cfg_mon     (cfg_bus),
		.errors      (errors),
		.outstanding (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Advance a request at a falling edge, idling first at the phase's rate,
	// then hold it until the block takes it.
	task automatic send_req(input func_t f, input logic [2:0] ch,
		input logic signed [23:0] s, input logic [4:0] ix,
		input logic signed [31:0] v);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < gap_pct) in_bus.valid = 1'b0;
			else break;
		end
		in_bus.valid      = 1'b1;
		in_bus.func       = f;
		in_bus.channel    = ch;
		in_bus.sample     = s;
		in_bus.coef_index = ix;
		in_bus.coef_value = v;
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
	endtask

	// Drop valid, wait for every result, then let coefficient or arm work finish.
	task automatic drain();
		@(negedge clk);
		in_bus.valid = 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// The block must be idle here; call only after drain.
	task automatic write_order(input logic [3:0] ord);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.data  = ord;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic send_coef(input int ix, input logic signed [31:0] v);
		send_req(FUNC_COEF, 3'd0, 24'sd0, 5'(ix), v);
	endtask

	task automatic send_sample(input int ch, input logic signed [23:0] s);
		send_req(FUNC_FILTER, 3'(ch), s, 5'd0, 32'sd0);
	endtask

	// Mostly filter requests with moderate samples, plus coefficient writes
	// with mostly small values, re-arms, and a little noise.
	task automatic random_req();
		int                 r;
		logic signed [31:0] v;
		logic signed [23:0] s;
		r = $urandom_range(99);
		if (r < 3) begin
			send_req(FUNC_NONE, 3'($urandom), 24'($urandom), 5'($urandom), $urandom);
		end else if (r < 8) begin
			send_req(FUNC_ARM, 3'($urandom), 24'($urandom), 5'($urandom), $urandom);
		end else if (r < 20) begin
			if ($urandom_range(19) == 0) v = $urandom;
			else v = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
			send_coef(($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16), v);
		end else begin
			s = 24'($urandom);
			s = s >>> $urandom_range(0, 4);
			send_sample($urandom_range(0, 7), s);
		end
	endtask

	// Receiver: random stalls, or one long hold-off so the block backs up.
	initial begin
		out_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_bus.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold = 1'b0;
			end else begin
				out_bus.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WDOG_MAX) begin
				$display("[multichannel_iir_direct_form_one] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int orders [8];
		orders = '{1, 8, 0, 15, 3, 6, 2, 5};
		in_bus.valid      = 1'b0;
		in_bus.func       = FUNC_FILTER;
		in_bus.channel    = '0;
		in_bus.sample     = '0;
		in_bus.coef_index = '0;
		in_bus.coef_value = '0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.data      = '0;
		gap_pct   = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		arst_n    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: disarmed pass-through first, at the reset order.
		send_sample(0, 24'sh7FFFFF);
		send_sample(7, -24'sh800000);
		send_coef(0, 32'sh0800_0000);            // b0 = 0.5
		send_coef(1, 32'sh0400_0000);            // ff1 = 0.25
		send_coef(9, -32'sh0200_0000);           // fb1 = -0.125
		send_coef(16, 32'sh0100_0000);           // last feedback tap
		send_coef(31, 32'sh7FFF_FFFF);           // out of range, ignored
		send_req(FUNC_NONE, 3'd5, 24'sh123456, 5'd3, 32'sh1);
		send_req(FUNC_ARM, 3'd0, 24'sd0, 5'd0, 32'sd0);
		send_sample(0, 24'sh7FFFFF);
		send_sample(0, -24'sh800000);
		send_sample(0, 24'sd0);
		send_sample(3, 24'sd1);
		send_sample(7, -24'sd1);
		// Overflow: b0 near 8.0 with a full-scale sample, then disarmed.
		send_coef(0, 32'sh7FFF_FFFF);
		send_sample(2, 24'sh7FFFFF);
		send_sample(2, 24'sh100000);
		send_coef(0, -32'sh8000_0000);
		send_req(FUNC_ARM, 3'd0, 24'sd0, 5'd0, 32'sd0);
		send_sample(4, -24'sh800000);
		send_sample(4, 24'sh000010);
		send_coef(0, 32'sh0800_0000);
		send_sample(4, 24'sh400000);
		drain();

		// Random phases: one order setting and idling mode each.
		for (int ph = 0; ph < 8; ph++) begin
			write_order(4'(orders[ph]));
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 59; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 59; end
				default: begin gap_pct = 30; stall_pct = 30; end
			endcase
			send_req(FUNC_ARM, 3'd0, 24'sd0, 5'd0, 32'sd0);
			for (int i = 0; i < 200; i++) begin
				if (ph == 0 && i == 40) long_hold = 1'b1;
				// Pause the sender until every result is home.
				if (ph == 1 && i == 100) begin
					@(negedge clk);
					in_bus.valid = 1'b0;
					wait (pending == 0);
				end
				random_req();
			end
			drain();
		end

		if (errors == 0)
			$display("[multichannel_iir_direct_form_one] OK");
		else
			$display("[multichannel_iir_direct_form_one] ERROR");
		$finish;
	end
endmodule
